### rtl/bdt_pkg.sv
// ----------------------------------------------------------------------------
// bdt_pkg
// Shared types, constants and helpers of the banded alignment core.
// ----------------------------------------------------------------------------
package bdt_pkg;

  localparam int SW     = 44;
  localparam int NUM_W  = 34;
  localparam int DEN_W  = 17;
  localparam int PROD_W = 49;

  localparam logic signed [SW-1:0] INF_Q  = 44'sd65536000000;
  localparam logic signed [SW-1:0] BEST_Q = 44'sd19661;
  localparam logic [14:0]          BEST_U = 15'd19661;
  localparam logic [NUM_W-1:0]     ONE_Q  = 34'd65536;
  localparam logic signed [39:0]   SKIP_RESET = -40'sd19661;
  localparam logic signed [SW-1:0] SAT_MAX = 44'sd549755813887;
  localparam logic signed [SW-1:0] SAT_MIN = -44'sd549755813888;

  localparam logic [2:0] MV_DIAG    = 3'd0;
  localparam logic [2:0] MV_SRC     = 3'd1;
  localparam logic [2:0] MV_DST     = 3'd2;
  localparam logic [2:0] MV_TWO_ONE = 3'd3;
  localparam logic [2:0] MV_ONE_TWO = 3'd4;
  localparam logic [2:0] MV_DEAD    = 3'd5;

  localparam logic [1:0] CFG_SKIP = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;
  localparam logic [1:0] CFG_COLS = 2'd2;

  localparam logic [1:0] K_DIAG = 2'd0;
  localparam logic [1:0] K_TWO  = 2'd1;
  localparam logic [1:0] K_LAST = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [10:0]        row;
    logic [10:0]        col;
    logic signed [39:0] sim_diag;
    logic signed [39:0] sim_up_two;
    logic signed [39:0] sim_left_two;
    logic [15:0]        src_len_prev;
    logic [15:0]        src_len_prev2;
    logic [15:0]        dst_len_prev;
    logic [15:0]        dst_len_prev2;
  } item_t;

  typedef struct packed {
    logic signed [39:0] cell_score;
    logic [2:0]         move;
    logic [10:0]        trail_row;
    logic [10:0]        trail_col;
    logic               last;
    logic               bad_trail;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CROW, S_DSTART, S_DWAIT, S_MUL, S_BON, S_PREP1, S_PREP2,
    S_RD, S_SUB, S_CMP, S_FIN, S_TSTART, S_TOFF, S_TOFFW, S_TMVW, S_TEMIT
  } back_state_t;

  function automatic logic [1:0] mod3(input logic [10:0] v);
    logic [11:0] w;
    logic [4:0]  s;
    w = {1'b0, v};
    s = '0;
    for (int i = 0; i < 6; i++) begin
      s = s + {3'b0, w[2*i +: 2]};
    end
    for (int i = 0; i < 6; i++) begin
      if (s >= 5'd3) begin
        s = s - 5'd3;
      end
    end
    return s[1:0];
  endfunction

endpackage

### rtl/banded_alignment_dp_with_traceback_core.sv
// ----------------------------------------------------------------------------
// banded_alignment_dp_with_traceback_core
// Banded sentence alignment matrix with stored moves and traceback walk.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; up to two requests
// queue ahead of the engine. Every request yields exactly one result, shown
// for a single cycle with out_valid, and the receiver cannot stall it. A cell
// request runs three length-closeness divisions on one shared divider, then
// five score-memory reads, one candidate each, on the single read port. A
// trace request reads the band-offset and move memories in series. The user
// must write configuration only while no request is in flight; the block
// itself does not enforce it.
module banded_alignment_dp_with_traceback_core import bdt_pkg::*; #(
  parameter int MAX_SENTENCES = 1024,
  parameter int BAND_WIDTH    = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic [10:0]        in_row,
  input  logic [10:0]        in_col,
  input  logic signed [39:0] in_sim_diag,
  input  logic signed [39:0] in_sim_up_two,
  input  logic signed [39:0] in_sim_left_two,
  input  logic [15:0]        in_src_len_prev,
  input  logic [15:0]        in_src_len_prev2,
  input  logic [15:0]        in_dst_len_prev,
  input  logic [15:0]        in_dst_len_prev2,
  output logic               out_valid,
  output logic signed [39:0] out_cell_score,
  output logic [2:0]         out_move,
  output logic [10:0]        out_trail_row,
  output logic [10:0]        out_trail_col,
  output logic               out_last,
  output logic               out_bad_trail,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [39:0]        cfg_data
);

  logic signed [39:0] skip_r;
  logic [10:0]        rows_r;
  logic [10:0]        cols_r;
  item_t              in_item;
  logic               q_valid;
  item_t              q_item;
  logic               q_pop;
  res_t               res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= SKIP_RESET;
      rows_r <= '0;
      cols_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SKIP: skip_r <= cfg_data;
        CFG_ROWS: rows_r <= cfg_data[10:0];
        CFG_COLS: cols_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.kind          = in_kind;
    in_item.row           = in_row;
    in_item.col           = in_col;
    in_item.sim_diag      = in_sim_diag;
    in_item.sim_up_two    = in_sim_up_two;
    in_item.sim_left_two  = in_sim_left_two;
    in_item.src_len_prev  = in_src_len_prev;
    in_item.src_len_prev2 = in_src_len_prev2;
    in_item.dst_len_prev  = in_dst_len_prev;
    in_item.dst_len_prev2 = in_dst_len_prev2;
  end

  bdt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .busy    (busy),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  bdt_back #(
    .MAX_SENTENCES (MAX_SENTENCES),
    .BAND_WIDTH    (BAND_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .skip_score (skip_r),
    .row_count  (rows_r),
    .col_count  (cols_r),
    .res_valid  (out_valid),
    .res        (res)
  );

  assign out_cell_score = res.cell_score;
  assign out_move       = res.move;
  assign out_trail_row  = res.trail_row;
  assign out_trail_col  = res.trail_col;
  assign out_last       = res.last;
  assign out_bad_trail  = res.bad_trail;

endmodule

### rtl/bdt_ram.sv
// ----------------------------------------------------------------------------
// bdt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### rtl/bdt_div.sv
// ----------------------------------------------------------------------------
// bdt_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bdt_div import bdt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  logic             busy_r;
  logic             done_r;
  logic [5:0]       cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W:0]   trial;
  logic             qbit;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign qbit  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      q_r   <= {q_r[NUM_W-2:0], qbit};
      num_r <= {num_r[NUM_W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

### rtl/bdt_front.sv
// ----------------------------------------------------------------------------
// bdt_front
// Request intake: two-entry queue ahead of the cell and trace engine.
// ----------------------------------------------------------------------------
module bdt_front import bdt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  item_t in_item,
  output logic  busy,
  output logic  q_valid,
  output item_t q_item,
  input  logic  q_pop
);

  item_t      mem_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;
  logic       push;

  assign busy    = cnt_r == 2'd2;
  assign push    = start && !busy;
  assign q_valid = cnt_r != 2'd0;
  assign q_item  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (q_pop) begin
        rptr_r <= !rptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= in_item;
    end
  end

endmodule

### rtl/bdt_back.sv
// ----------------------------------------------------------------------------
// bdt_back
// Cell recurrence and traceback sequencer with band, score and move stores.
// ----------------------------------------------------------------------------
module bdt_back import bdt_pkg::*; #(
  parameter int MAX_SENTENCES = 1024,
  parameter int BAND_WIDTH    = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  input  logic signed [39:0] skip_score,
  input  logic [10:0]        row_count,
  input  logic [10:0]        col_count,
  output logic               res_valid,
  output res_t               res
);

  localparam int OD = MAX_SENTENCES + 1;
  localparam int RW = $clog2(OD);
  localparam int MD = OD * BAND_WIDTH;
  localparam int MW = $clog2(MD);
  localparam int SD = 3 * BAND_WIDTH;
  localparam int SA = $clog2(SD);

  back_state_t state_r, state_nxt;

  item_t              it_r;
  logic [1:0]         slot0_r, slot1_r, slot2_r;
  logic [10:0]        lo_r [3];
  logic [11:0]        hi_r [3];
  logic [10:0]        last_row_r;
  logic               row_seen_r;
  logic [10:0]        trace_row_r, trace_col_r;
  logic               started_r;
  logic [MW-1:0]      rbw_r;
  logic [1:0]         k_r;
  logic [2:0]         j_r;
  logic [PROD_W-1:0]  prod_r;
  logic signed [SW-1:0] bonus_r [3];
  logic signed [SW-1:0] d0_r, msu_r, msl_r, s3_r, s4_r;
  logic signed [SW-1:0] cand_r, best_r;
  logic [2:0]         dir_r;
  logic               cvalid_r, ccond_r;
  logic [2:0]         code_r;
  logic               res_valid_r;
  res_t               res_r;

  logic               div_start, div_done;
  logic [NUM_W-1:0]   div_num, div_q;
  logic [DEN_W-1:0]   div_den;
  logic [17:0]        cx, cy, chi;
  logic [16:0]        clo;

  logic               score_we;
  logic [SA-1:0]      score_waddr, score_raddr;
  logic [39:0]        score_rdata;
  logic               mv_we;
  logic [MW-1:0]      mv_waddr, mv_raddr;
  logic [2:0]         mv_rdata;
  logic               boff_we;
  logic [RW-1:0]      boff_raddr;
  logic [10:0]        boff_rdata;

  logic [1:0]         s_cur;
  logic               new_row, contig, row_ok;
  logic [1:0]         cs, rd_slot;
  logic [10:0]        cc;
  logic               cond, inband;
  logic signed [SW-1:0] csub, skip_x, sd_x, min_su, min_sl, base, best_sat;
  logic [10:0]        lo_sel;
  logic [11:0]        hi_sel;
  logic               store_ok;
  logic [10:0]        kcol;
  logic [MW-1:0]      rbw_nxt;
  logic [RW-1:0]      ridx;
  logic               t_last, t_bad;
  logic [10:0]        t_nr, t_nc, pc_off;
  logic               tr_ok;

  function automatic logic [SA-1:0] sbase(input logic [1:0] s);
    case (s)
      2'd0:    return '0;
      2'd1:    return SA'(BAND_WIDTH);
      default: return SA'(2 * BAND_WIDTH);
    endcase
  endfunction

  // row bookkeeping
  assign s_cur   = mod3(it_r.row);
  assign new_row = !row_seen_r || (it_r.row != last_row_r);
  assign contig  = row_seen_r && ({1'b0, it_r.row} == {1'b0, last_row_r} + 12'd1);
  assign row_ok  = 32'(it_r.row) <= 32'(MAX_SENTENCES);
  assign ridx    = RW'((state_r == S_CROW) ? it_r.row : trace_row_r);
  assign rbw_nxt = MW'(ridx) * MW'(BAND_WIDTH);

  assign skip_x = {{(SW-40){skip_score[39]}}, skip_score};
  assign sd_x   = {{(SW-40){it_r.sim_diag[39]}}, it_r.sim_diag};
  assign min_su = (it_r.sim_diag < it_r.sim_up_two) ? sd_x :
                  {{(SW-40){it_r.sim_up_two[39]}}, it_r.sim_up_two};
  assign min_sl = (it_r.sim_diag < it_r.sim_left_two) ? sd_x :
                  {{(SW-40){it_r.sim_left_two[39]}}, it_r.sim_left_two};

  // closeness operands
  always_comb begin
    case (k_r)
      K_DIAG: begin
        cx = {2'b0, it_r.src_len_prev};
        cy = {2'b0, it_r.dst_len_prev};
      end
      K_TWO: begin
        cx = {2'b0, it_r.src_len_prev2} + {2'b0, it_r.src_len_prev} + 18'd2;
        cy = {2'b0, it_r.dst_len_prev};
      end
      default: begin
        cx = {2'b0, it_r.dst_len_prev2} + {2'b0, it_r.dst_len_prev} + 18'd2;
        cy = {2'b0, it_r.src_len_prev};
      end
    endcase
    chi = ((cx > cy) ? cx : cy) + 18'd1;
    clo = 17'(((cx > cy) ? cy : cx) + 18'd1);
  end

  assign div_num = {chi, 16'b0};
  assign div_den = clo;

  // candidate select
  always_comb begin
    case (j_r)
      MV_DIAG: begin
        cs = slot1_r; cc = it_r.col - 11'd1; csub = d0_r;
        cond = (it_r.row != '0) && (it_r.col != '0);
      end
      MV_SRC: begin
        cs = slot1_r; cc = it_r.col; csub = skip_x;
        cond = it_r.row != '0;
      end
      MV_DST: begin
        cs = slot0_r; cc = it_r.col - 11'd1; csub = skip_x;
        cond = it_r.col != '0;
      end
      MV_TWO_ONE: begin
        cs = slot2_r; cc = it_r.col - 11'd1; csub = s3_r;
        cond = (it_r.row > 11'd1) && (it_r.col != '0);
      end
      default: begin
        cs = slot1_r; cc = it_r.col - 11'd2; csub = s4_r;
        cond = (it_r.row != '0) && (it_r.col > 11'd1);
      end
    endcase
  end

  assign rd_slot     = (state_r == S_FIN) ? slot0_r : cs;
  assign lo_sel      = lo_r[rd_slot];
  assign hi_sel      = hi_r[rd_slot];
  assign inband      = (cc >= lo_sel) && ({1'b0, cc} < hi_sel);
  assign score_raddr = sbase(cs) + SA'(cc - lo_sel);
  assign base        = cvalid_r ? {{(SW-40){score_rdata[39]}}, score_rdata} : INF_Q;

  // store of the finished cell
  assign kcol     = it_r.col - lo_sel;
  assign store_ok = ({1'b0, it_r.col} == hi_sel)
                    && (32'(hi_sel - {1'b0, lo_sel}) < 32'(BAND_WIDTH));
  always_comb begin
    if (dir_r == MV_DEAD) begin
      best_sat = '0;
    end else if (best_r > SAT_MAX) begin
      best_sat = SAT_MAX;
    end else if (best_r < SAT_MIN) begin
      best_sat = SAT_MIN;
    end else begin
      best_sat = best_r;
    end
  end
  assign score_waddr = sbase(slot0_r) + SA'(kcol);
  assign mv_waddr    = rbw_r + MW'(kcol);

  // traceback lookups
  assign boff_raddr = RW'(trace_row_r);
  assign pc_off     = trace_col_r - boff_rdata;
  assign tr_ok      = (trace_col_r >= boff_rdata) && (32'(pc_off) < 32'(BAND_WIDTH));
  assign mv_raddr   = rbw_r + MW'(pc_off);

  always_comb begin
    t_last = 1'b0;
    t_bad  = 1'b0;
    t_nr   = trace_row_r;
    t_nc   = trace_col_r;
    case (code_r)
      MV_DIAG: begin
        t_nr = trace_row_r - 11'd1;
        t_nc = trace_col_r - 11'd1;
      end
      MV_SRC: t_nr = trace_row_r - 11'd1;
      MV_DST: t_nc = trace_col_r - 11'd1;
      MV_TWO_ONE: begin
        if (trace_row_r < 11'd2) begin
          t_bad = 1'b1;
        end else begin
          t_nr = trace_row_r - 11'd2;
          t_nc = trace_col_r - 11'd1;
        end
      end
      MV_ONE_TWO: begin
        if (trace_col_r < 11'd2) begin
          t_bad = 1'b1;
        end else begin
          t_nr = trace_row_r - 11'd1;
          t_nc = trace_col_r - 11'd2;
        end
      end
      MV_DEAD: t_last = 1'b1;
      default: t_bad = 1'b1;
    endcase
    t_last = t_last || t_bad;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    boff_we   = 1'b0;
    score_we  = 1'b0;
    mv_we     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = q_item.kind ? S_TSTART : S_CROW;
        end
      end
      S_CROW: begin
        boff_we   = new_row && row_ok;
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        div_start = 1'b1;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:   state_nxt = S_BON;
      S_BON:   state_nxt = (k_r == K_LAST) ? S_PREP1 : S_DSTART;
      S_PREP1: state_nxt = S_PREP2;
      S_PREP2: state_nxt = S_RD;
      S_RD:    state_nxt = S_SUB;
      S_SUB:   state_nxt = S_CMP;
      S_CMP:   state_nxt = (j_r == MV_ONE_TWO) ? S_FIN : S_RD;
      S_FIN: begin
        score_we  = store_ok;
        mv_we     = store_ok && row_ok;
        state_nxt = S_IDLE;
      end
      S_TSTART: state_nxt = S_TOFF;
      S_TOFF: begin
        if ((trace_row_r == '0) || (trace_col_r == '0)
            || (32'(trace_row_r) > 32'(MAX_SENTENCES))) begin
          state_nxt = S_TEMIT;
        end else begin
          state_nxt = S_TOFFW;
        end
      end
      S_TOFFW: state_nxt = tr_ok ? S_TMVW : S_TEMIT;
      S_TMVW:  state_nxt = S_TEMIT;
      S_TEMIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        lo_r[i] <= '0;
        hi_r[i] <= '0;
      end
      last_row_r  <= '0;
      row_seen_r  <= 1'b0;
      trace_row_r <= '0;
      trace_col_r <= '0;
      started_r   <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= 1'b0;
      case (state_r)
        S_CROW: begin
          started_r <= 1'b0;
          if (new_row) begin
            if (!contig) begin
              for (int i = 0; i < 3; i++) begin
                lo_r[i] <= '0;
                hi_r[i] <= '0;
              end
            end
            lo_r[s_cur] <= it_r.col;
            hi_r[s_cur] <= {1'b0, it_r.col};
            last_row_r  <= it_r.row;
            row_seen_r  <= 1'b1;
          end
        end
        S_FIN: begin
          res_valid_r <= 1'b1;
          if (store_ok) begin
            hi_r[slot0_r] <= {1'b0, it_r.col} + 12'd1;
          end
        end
        S_TSTART: begin
          if (!started_r) begin
            trace_row_r <= row_count;
            trace_col_r <= col_count;
            started_r   <= 1'b1;
          end
        end
        S_TEMIT: begin
          res_valid_r <= 1'b1;
          if (t_last) begin
            started_r <= 1'b0;
          end else begin
            trace_row_r <= t_nr;
            trace_col_r <= t_nc;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        it_r <= q_item;
        k_r  <= K_DIAG;
      end
      S_CROW: begin
        slot0_r <= s_cur;
        slot1_r <= (s_cur == 2'd0) ? 2'd2 : s_cur - 2'd1;
        slot2_r <= (s_cur == 2'd0) ? 2'd1 : ((s_cur == 2'd1) ? 2'd2 : 2'd0);
        rbw_r   <= rbw_nxt;
      end
      S_MUL: prod_r <= PROD_W'((div_q - ONE_Q) * BEST_U);
      S_BON: begin
        bonus_r[k_r] <= BEST_Q - SW'(prod_r[PROD_W-1:16]);
        k_r          <= k_r + 2'd1;
      end
      S_PREP1: begin
        d0_r  <= sd_x + bonus_r[K_DIAG];
        msu_r <= min_su + skip_x;
        msl_r <= min_sl + skip_x;
      end
      S_PREP2: begin
        s3_r   <= msu_r + bonus_r[K_TWO];
        s4_r   <= msl_r + bonus_r[K_LAST];
        best_r <= INF_Q;
        dir_r  <= MV_DEAD;
        j_r    <= MV_DIAG;
      end
      S_RD: begin
        cvalid_r <= cond && inband;
        ccond_r  <= cond;
      end
      S_SUB: cand_r <= base - csub;
      S_CMP: begin
        if (ccond_r && (cand_r < best_r)) begin
          best_r <= cand_r;
          dir_r  <= j_r;
        end
        j_r <= j_r + 3'd1;
      end
      S_FIN: begin
        res_r.cell_score <= best_sat[39:0];
        res_r.move       <= dir_r;
        res_r.trail_row  <= '0;
        res_r.trail_col  <= '0;
        res_r.last       <= 1'b0;
        res_r.bad_trail  <= 1'b0;
      end
      S_TSTART: code_r <= MV_DEAD;
      S_TOFF:   rbw_r  <= rbw_nxt;
      S_TMVW:   code_r <= mv_rdata;
      S_TEMIT: begin
        res_r.cell_score <= '0;
        res_r.move       <= MV_DIAG;
        res_r.trail_row  <= trace_row_r;
        res_r.trail_col  <= trace_col_r;
        res_r.last       <= t_last;
        res_r.bad_trail  <= t_bad;
      end
      default: ;
    endcase
  end

  bdt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  bdt_ram #(.WIDTH(40), .DEPTH(SD)) u_score_ram (
    .clk   (clk),
    .we    (score_we),
    .waddr (score_waddr),
    .wdata (best_sat[39:0]),
    .raddr (score_raddr),
    .rdata (score_rdata)
  );

  bdt_ram #(.WIDTH(3), .DEPTH(MD)) u_move_ram (
    .clk   (clk),
    .we    (mv_we),
    .waddr (mv_waddr),
    .wdata (dir_r),
    .raddr (mv_raddr),
    .rdata (mv_rdata)
  );

  bdt_ram #(.WIDTH(11), .DEPTH(OD)) u_boff_ram (
    .clk   (clk),
    .we    (boff_we),
    .waddr (ridx),
    .wdata (it_r.col),
    .raddr (boff_raddr),
    .rdata (boff_rdata)
  );

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

### rtl/bdt_checker.sv
// ----------------------------------------------------------------------------
// bdt_checker
// Port-level checks on the result channel of the alignment core.
// ----------------------------------------------------------------------------
module bdt_checker import bdt_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic signed [39:0] out_cell_score,
  input logic [2:0]         out_move,
  input logic               out_last,
  input logic               out_bad_trail
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_trail |-> out_last)
    else $error("bad trail point not marked last");

  a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_move == MV_DEAD) |-> out_cell_score == '0)
    else $error("dead cell with nonzero score");

  a_move_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_move <= MV_DEAD)
    else $error("move code out of range");

  a_trace_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> (out_move == MV_DIAG) && (out_cell_score == '0))
    else $error("trail point carries cell fields");

endmodule

bind banded_alignment_dp_with_traceback_core bdt_checker u_bdt_checker (.*);
